// ----- rtl/ccss_pkg.sv -----
// ----------------------------------------------------------------------------
// ccss_pkg
// Types and constants shared by the coincidence single sequence sorter.
// ----------------------------------------------------------------------------
package ccss_pkg;

    localparam int ENERGY_W = 24;
    localparam int POS_W    = 24;
    localparam int TAG_W    = 8;
    localparam int KEY_W    = 24;
    localparam int MODE_W   = 2;

    // depth of the queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic [MODE_W-1:0] MODE_ARRIVAL = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ENERGY  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DIST    = 2'd2;

    typedef struct packed {
        logic        [ENERGY_W-1:0] energy;
        logic signed [POS_W-1:0]    z;
        logic signed [POS_W-1:0]    source_z;
        logic        [TAG_W-1:0]    tag;
    } t_single;

    typedef struct packed {
        t_single          single;
        logic             last;
        logic [KEY_W-1:0] span;
    } t_entry;

endpackage

// ----- rtl/ccss_front.sv -----
// ----------------------------------------------------------------------------
// ccss_front
// Accepts singles, works out |hit_z - source_z| and queues them for the back.
// ----------------------------------------------------------------------------
module ccss_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [ccss_pkg::ENERGY_W-1:0]        i_hit_energy,
    input  logic signed [ccss_pkg::POS_W-1:0]    i_hit_z,
    input  logic signed [ccss_pkg::POS_W-1:0]    i_source_z,
    input  logic [ccss_pkg::TAG_W-1:0]           i_single_tag,
    input  logic                                 i_last_in,
    output logic                                 o_q_valid,
    input  logic                                 i_q_pop,
    output ccss_pkg::t_entry                     o_q_entry
);
    import ccss_pkg::*;

    t_entry                     r_mem [FIFO_DEPTH];
    logic   [FIFO_PW-1:0]       r_wr_ptr;
    logic   [FIFO_PW-1:0]       r_rd_ptr;
    logic   [FIFO_CW-1:0]       r_count;
    logic signed [POS_W:0]      w_diff;
    logic   [POS_W:0]           w_abs;
    t_entry                     w_entry;
    logic                       w_push;
    logic                       w_pop;

    always_comb begin
        w_diff = {i_hit_z[POS_W-1], i_hit_z} - {i_source_z[POS_W-1], i_source_z};
        w_abs  = w_diff[POS_W] ? (~w_diff + 1'b1) : w_diff;
        w_entry.single.energy   = i_hit_energy;
        w_entry.single.z        = i_hit_z;
        w_entry.single.source_z = i_source_z;
        w_entry.single.tag      = i_single_tag;
        w_entry.last            = i_last_in;
        w_entry.span            = w_abs[KEY_W-1:0];
    end

    assign o_stall   = (r_count == FIFO_CW'(FIFO_DEPTH));
    assign w_push    = i_valid && !o_stall;
    assign o_q_valid = (r_count != '0);
    assign w_pop     = o_q_valid && i_q_pop;
    assign o_q_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/ccss_chain.sv -----
// ----------------------------------------------------------------------------
// ccss_chain
// Insertion chain of sorted (key, slot) cells. Every cell compares its own key
// with the incoming one; cells above the insertion point shift up by one.
// ----------------------------------------------------------------------------
module ccss_chain #(
    parameter int DEPTH = 8
) (
    input  logic                               i_clk,
    input  logic                               i_ins,
    input  logic [$clog2(DEPTH+1)-1:0]         i_cnt,
    input  logic [ccss_pkg::KEY_W-1:0]         i_key,
    input  logic [$clog2(DEPTH)-1:0]           i_slot,
    input  logic [$clog2(DEPTH)-1:0]           i_rd_pos,
    output logic [$clog2(DEPTH)-1:0]           o_rd_slot
);
    import ccss_pkg::*;

    localparam int SW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [KEY_W-1:0] r_key  [DEPTH];
    logic [SW-1:0]    r_slot [DEPTH];
    logic [DEPTH-1:0] w_gt;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic             w_from_prev;
        logic [KEY_W-1:0] w_prev_key;
        logic [SW-1:0]    w_prev_slot;

        // strict compare: an equal key lands after the held one
        assign w_gt[g] = (CW'(g) < i_cnt) && (r_key[g] > i_key);

        if (g == 0) begin : g_head
            assign w_from_prev = 1'b0;
            assign w_prev_key  = i_key;
            assign w_prev_slot = i_slot;
        end else begin : g_body
            assign w_from_prev = w_gt[g-1];
            assign w_prev_key  = r_key[g-1];
            assign w_prev_slot = r_slot[g-1];
        end

        always_ff @(posedge i_clk) begin
            if (i_ins && (w_gt[g] || CW'(g) == i_cnt)) begin
                r_key[g]  <= w_from_prev ? w_prev_key  : i_key;
                r_slot[g] <= w_from_prev ? w_prev_slot : i_slot;
            end
        end
    end

    assign o_rd_slot = r_slot[i_rd_pos];

endmodule

// ----- rtl/ccss_back.sv -----
// ----------------------------------------------------------------------------
// ccss_back
// Holds the singles of one coincidence, keeps them ordered by energy and by
// axial distance as they arrive, and emits them once the last one is in.
// ----------------------------------------------------------------------------
module ccss_back #(
    parameter int MAX_SINGLES = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [ccss_pkg::MODE_W-1:0]          i_mode,
    input  logic                                 i_q_valid,
    output logic                                 o_q_pop,
    input  ccss_pkg::t_entry                     i_q_entry,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output ccss_pkg::t_single                    o_single,
    output logic                                 o_last,
    output logic                                 o_overflowed
);
    import ccss_pkg::*;

    localparam int SW = $clog2(MAX_SINGLES);
    localparam int CW = $clog2(MAX_SINGLES + 1);

    localparam logic ST_COLLECT = 1'b0;
    localparam logic ST_EMIT    = 1'b1;

    t_single            r_store [MAX_SINGLES];
    logic               r_state;
    logic [CW-1:0]      r_cnt;
    logic               r_drop;
    logic [MODE_W-1:0]  r_mode;
    logic [SW-1:0]      r_idx;
    logic               r_out_valid;
    t_single            r_out;
    logic               r_out_last;
    logic               r_out_ovf;

    logic               w_room;
    logic               w_pop;
    logic               w_ins;
    logic               w_load;
    logic               w_final;
    logic [SW-1:0]      w_e_slot;
    logic [SW-1:0]      w_d_slot;
    logic [SW-1:0]      w_sel;

    assign w_room  = (r_cnt < CW'(MAX_SINGLES));
    assign w_pop   = (r_state == ST_COLLECT) && i_q_valid;
    assign w_ins   = w_pop && w_room;
    assign w_load  = (r_state == ST_EMIT) && (!r_out_valid || !i_stall);
    assign w_final = (CW'(r_idx) == r_cnt - CW'(1));
    assign o_q_pop = w_pop;

    ccss_chain #(.DEPTH(MAX_SINGLES)) u_energy_chain (
        .i_clk     (i_clk),
        .i_ins     (w_ins),
        .i_cnt     (r_cnt),
        .i_key     (i_q_entry.single.energy),
        .i_slot    (r_cnt[SW-1:0]),
        .i_rd_pos  (r_idx),
        .o_rd_slot (w_e_slot)
    );

    ccss_chain #(.DEPTH(MAX_SINGLES)) u_dist_chain (
        .i_clk     (i_clk),
        .i_ins     (w_ins),
        .i_cnt     (r_cnt),
        .i_key     (i_q_entry.span),
        .i_slot    (r_cnt[SW-1:0]),
        .i_rd_pos  (r_idx),
        .o_rd_slot (w_d_slot)
    );

    always_comb begin
        case (r_mode)
            MODE_ENERGY: w_sel = w_e_slot;
            MODE_DIST:   w_sel = w_d_slot;
            default:     w_sel = r_idx;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_ins) begin
            r_store[r_cnt[SW-1:0]] <= i_q_entry.single;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out      <= r_store[w_sel];
            r_out_last <= w_final;
            r_out_ovf  <= r_drop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_COLLECT;
            r_cnt       <= '0;
            r_drop      <= 1'b0;
            r_mode      <= MODE_ARRIVAL;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_COLLECT: begin
                    if (w_pop) begin
                        if (w_room) begin
                            r_cnt <= r_cnt + 1'b1;
                        end else begin
                            r_drop <= 1'b1;
                        end
                        // ordering policy is taken when the last single arrives
                        if (i_q_entry.last) begin
                            r_mode  <= i_mode;
                            r_idx   <= '0;
                            r_state <= ST_EMIT;
                        end
                    end
                end
                ST_EMIT: begin
                    if (w_load) begin
                        r_idx <= r_idx + 1'b1;
                        if (w_final) begin
                            r_cnt   <= '0;
                            r_drop  <= 1'b0;
                            r_state <= ST_COLLECT;
                        end
                    end
                end
                default: begin
                    r_state <= ST_COLLECT;
                end
            endcase

            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_single     = r_out;
    assign o_last       = r_out_last;
    assign o_overflowed = r_out_ovf;

endmodule

// ----- rtl/coincidence_single_sequence_sorter.sv -----
// ----------------------------------------------------------------------------
// coincidence_single_sequence_sorter
// Reorders the singles of one coincidence by arrival, energy or axial distance.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_stall): one single per transaction, i_last_in set
// on the final single of a coincidence. Singles are taken one per cycle into a
// four-entry queue; the back drains it at one per cycle, inserting each single
// into two sorted cell chains (energy and |hit_z - source_z|).
// Output channel (o_valid / i_stall): one transaction per held single, in the
// order chosen by i_cfg_wr_data (0 arrival, 1 energy, 2 distance, 3 arrival),
// sampled when the last single leaves the queue. Ties keep arrival order.
// Once the back pops the last single it switches to emitting, and the first
// result is registered in the output stage; the n kept results then follow
// one per cycle while i_stall is low. While they are emitted the back takes
// nothing, so the input stalls once the queue is full.
// Singles beyond MAX_SINGLES are dropped and o_overflowed is set on every
// result of that coincidence. A stalled result holds until taken.
// Reset clears the queue, the held count, the overflow flag, the output valid
// and sets the mode to arrival order.
// ----------------------------------------------------------------------------
module coincidence_single_sequence_sorter #(
    parameter int MAX_SINGLES = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [ccss_pkg::MODE_W-1:0]          i_cfg_wr_data,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [ccss_pkg::ENERGY_W-1:0]        i_hit_energy,
    input  logic signed [ccss_pkg::POS_W-1:0]    i_hit_z,
    input  logic signed [ccss_pkg::POS_W-1:0]    i_source_z,
    input  logic [ccss_pkg::TAG_W-1:0]           i_single_tag,
    input  logic                                 i_last_in,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [ccss_pkg::ENERGY_W-1:0]        o_out_energy,
    output logic signed [ccss_pkg::POS_W-1:0]    o_out_z,
    output logic signed [ccss_pkg::POS_W-1:0]    o_out_source_z,
    output logic [ccss_pkg::TAG_W-1:0]           o_out_tag,
    output logic                                 o_last_out,
    output logic                                 o_overflowed
);
    import ccss_pkg::*;

    logic [MODE_W-1:0]  r_sequence_mode;
    logic               w_q_valid;
    logic               w_q_pop;
    t_entry             w_q_entry;
    t_single            w_single;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sequence_mode <= MODE_ARRIVAL;
        end else if (i_cfg_wr_en) begin
            r_sequence_mode <= i_cfg_wr_data;
        end
    end

    ccss_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_hit_energy (i_hit_energy),
        .i_hit_z      (i_hit_z),
        .i_source_z   (i_source_z),
        .i_single_tag (i_single_tag),
        .i_last_in    (i_last_in),
        .o_q_valid    (w_q_valid),
        .i_q_pop      (w_q_pop),
        .o_q_entry    (w_q_entry)
    );

    ccss_back #(.MAX_SINGLES(MAX_SINGLES)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_mode       (r_sequence_mode),
        .i_q_valid    (w_q_valid),
        .o_q_pop      (w_q_pop),
        .i_q_entry    (w_q_entry),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_single     (w_single),
        .o_last       (o_last_out),
        .o_overflowed (o_overflowed)
    );

    assign o_out_energy   = w_single.energy;
    assign o_out_z        = w_single.z;
    assign o_out_source_z = w_single.source_z;
    assign o_out_tag      = w_single.tag;

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the coincidence single sequence sorter. Coincidences
// of singles are pushed through the input channel under random gaps and the
// results are drained under random stall. An in-bench sorter works out the
// emission order for every accepted last single (arrival, energy, axial
// distance), and each result transaction is compared with the oldest
// outstanding expectation. Directed coincidences cover field extremes, ties,
// every mode and a full buffer; random coincidences follow.
// ----------------------------------------------------------------------------
module testbench;
    import ccss_pkg::*;

    localparam int MAX_SINGLES = 8;
    localparam int SETTLE_CYCLES = 24;
    localparam int RANDOM_SINGLES = 150;
    localparam logic [MODE_W-1:0] MODE_ARRIVAL_ALT = 2'd3;

    typedef struct {
        t_single hit;
        logic    last;
    } t_incoming;

    typedef struct {
        t_single hit;
        logic    last;
        logic    overflowed;
    } t_sorted;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_wr_en = 1'b0;
    logic [MODE_W-1:0] i_cfg_wr_data = '0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [ENERGY_W-1:0] i_hit_energy = '0;
    logic signed [POS_W-1:0] i_hit_z = '0;
    logic signed [POS_W-1:0] i_source_z = '0;
    logic [TAG_W-1:0] i_single_tag = '0;
    logic i_last_in = 1'b0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic [ENERGY_W-1:0] o_out_energy;
    logic signed [POS_W-1:0] o_out_z;
    logic signed [POS_W-1:0] o_out_source_z;
    logic [TAG_W-1:0] o_out_tag;
    logic o_last_out;
    logic o_overflowed;

    coincidence_single_sequence_sorter #(
        .MAX_SINGLES(MAX_SINGLES)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_hit_energy   (i_hit_energy),
        .i_hit_z        (i_hit_z),
        .i_source_z     (i_source_z),
        .i_single_tag   (i_single_tag),
        .i_last_in      (i_last_in),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_energy   (o_out_energy),
        .o_out_z        (o_out_z),
        .o_out_source_z (o_out_source_z),
        .o_out_tag      (o_out_tag),
        .o_last_out     (o_last_out),
        .o_overflowed   (o_overflowed)
    );

    always #5 i_clk = ~i_clk;

    t_incoming pending_singles[$];
    t_sorted   expected_singles[$];
    int unsigned queued_singles = 0;
    int unsigned taken_singles = 0;
    int unsigned mismatches = 0;
    bit steady = 1'b0;

    // sorter state mirrored in the bench
    t_single           held[MAX_SINGLES];
    int                held_n = 0;
    logic              lost_single = 1'b0;
    logic [MODE_W-1:0] order_mode = MODE_ARRIVAL;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    function automatic logic [24:0] sort_rank(t_single s, int idx);
        logic signed [24:0] d;
        d = $signed({s.z[POS_W-1], s.z}) - $signed({s.source_z[POS_W-1], s.source_z});
        case (order_mode)
            MODE_ENERGY: return {1'b0, s.energy};
            MODE_DIST:   return d[24] ? 25'(-d) : 25'(d);
            default:     return 25'(idx);
        endcase
    endfunction

    // stores the single; on a last single, sorts the held ones (stable) and queues them
    task automatic absorb_single(t_incoming s);
        logic [24:0] rank[MAX_SINGLES];
        int          slot[MAX_SINGLES];
        logic [24:0] k;
        t_sorted     r;
        int          n, i, j;
        if (held_n < MAX_SINGLES) begin
            held[held_n] = s.hit;
            held_n++;
        end else begin
            lost_single = 1'b1;
        end
        if (!s.last)
            return;
        n = held_n;
        for (i = 0; i < n; i++) begin
            k = sort_rank(held[i], i);
            j = i;
            while (j > 0 && rank[j-1] > k) begin
                rank[j] = rank[j-1];
                slot[j] = slot[j-1];
                j--;
            end
            rank[j] = k;
            slot[j] = i;
        end
        for (i = 0; i < n; i++) begin
            r.hit = held[slot[i]];
            r.last = (i == n - 1);
            r.overflowed = lost_single;
            expected_singles = {expected_singles, r};
        end
        held_n = 0;
        lost_single = 1'b0;
    endtask

    task automatic note_mismatch(string what);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // input side: one pending single per transaction, payload held while stalled
    int gap_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!(i_valid && o_stall)) begin
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (pending_singles.size() > 0) begin
                t_incoming s;
                s = pending_singles.pop_front();
                i_hit_energy <= s.hit.energy;
                i_hit_z <= s.hit.z;
                i_source_z <= s.hit.source_z;
                i_single_tag <= s.hit.tag;
                i_last_in <= s.last;
                i_valid <= 1'b1;
                gap_left = gap_len();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // output side stall
    int hold_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
            hold_left = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
        end
    end

    // monitor: predict on accepted singles, check accepted results
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                t_incoming s;
                s.hit.energy = i_hit_energy;
                s.hit.z = i_hit_z;
                s.hit.source_z = i_source_z;
                s.hit.tag = i_single_tag;
                s.last = i_last_in;
                absorb_single(s);
                taken_singles++;
            end
            if (o_valid && !i_stall) begin
                t_sorted e;
                if (expected_singles.size() == 0) begin
                    note_mismatch($sformatf("unexpected result tag %0h energy %0h",
                                            o_out_tag, o_out_energy));
                end else begin
                    e = expected_singles.pop_front();
                    if (o_out_energy !== e.hit.energy || o_out_z !== e.hit.z ||
                        o_out_source_z !== e.hit.source_z || o_out_tag !== e.hit.tag ||
                        o_last_out !== e.last || o_overflowed !== e.overflowed)
                        note_mismatch({
                            $sformatf("exp e=%h z=%h sz=%h tag=%h last=%b ovf=%b",
                                      e.hit.energy, e.hit.z, e.hit.source_z, e.hit.tag,
                                      e.last, e.overflowed),
                            $sformatf(", got e=%h z=%h sz=%h tag=%h last=%b ovf=%b",
                                      o_out_energy, o_out_z, o_out_source_z, o_out_tag,
                                      o_last_out, o_overflowed)});
                end
            end
        end
    end

    task automatic push_single(logic [23:0] energy, logic [23:0] z, logic [23:0] source_z,
                               logic [7:0] tag, logic last);
        t_incoming s;
        s.hit.energy = energy;
        s.hit.z = z;
        s.hit.source_z = source_z;
        s.hit.tag = tag;
        s.last = last;
        pending_singles = {pending_singles, s};
        queued_singles++;
    endtask

    task automatic push_random_single(logic last);
        logic [23:0] e, z, sz;
        int r;
        r = $urandom_range(0, 9);
        e = (r < 3) ? 24'($urandom_range(0, 3)) : (r < 4) ? 24'hFFFFFF : 24'($urandom);
        r = $urandom_range(0, 9);
        sz = (r < 3) ? 24'($urandom_range(0, 15)) - 24'd8 : 24'($urandom);
        r = $urandom_range(0, 9);
        // near the source, so distance ties turn up
        if (r < 3)
            z = sz + 24'($urandom_range(0, 6)) - 24'd3;
        else if (r < 4)
            z = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
        else
            z = 24'($urandom);
        push_single(e, z, sz, 8'($urandom), last);
    endtask

    task automatic wait_idle();
        while (taken_singles != queued_singles || expected_singles.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_mode(logic [MODE_W-1:0] m);
        wait_idle();
        // back end may still be draining its queue
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= m;
        order_mode = m;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    initial begin
        int sent, len, r, k;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes in arrival order
        set_mode(MODE_ARRIVAL);
        push_single(24'hFFFFFF, 24'h7FFFFF, 24'h800000, 8'hFF, 1'b1);
        push_single(24'h000000, 24'h800000, 24'h7FFFFF, 8'h00, 1'b0);
        push_single(24'hFFFFFF, 24'h000000, 24'hFFFFFF, 8'hAA, 1'b0);
        push_single(24'h000005, 24'h555555, 24'hAAAAAA, 8'h55, 1'b1);

        // energy with ties
        set_mode(MODE_ENERGY);
        push_single(24'd10, 24'd1, 24'd0, 8'h01, 1'b0);
        push_single(24'd5,  24'd2, 24'd0, 8'h02, 1'b0);
        push_single(24'd10, 24'd3, 24'd0, 8'h03, 1'b0);
        push_single(24'd5,  24'd4, 24'd0, 8'h04, 1'b1);

        // distance: largest span, zero, and equal distances either side
        steady = 1'b1;
        set_mode(MODE_DIST);
        push_single(24'd100, 24'h7FFFFF, 24'h800000, 8'h11, 1'b0);
        push_single(24'd200, 24'h000010, 24'h000010, 8'h12, 1'b0);
        push_single(24'd300, 24'hFFFFF0, 24'h000000, 8'h13, 1'b0);
        push_single(24'd400, 24'h000010, 24'h000000, 8'h14, 1'b1);

        // mode three behaves as arrival order
        set_mode(MODE_ARRIVAL_ALT);
        push_single(24'd3, 24'd30, 24'd0, 8'h21, 1'b0);
        push_single(24'd1, 24'd10, 24'd0, 8'h22, 1'b0);
        push_single(24'd2, 24'd20, 24'd0, 8'h23, 1'b1);
        steady = 1'b0;

        // full buffer: the ninth single, marked last, is dropped but ends the set
        set_mode(MODE_ENERGY);
        for (k = 0; k < MAX_SINGLES + 1; k++)
            push_single(24'(MAX_SINGLES - k), 24'(k), 24'd0, 8'(8'h30 + k),
                        k == MAX_SINGLES);

        // random coincidences, a few per mode setting
        sent = 0;
        while (sent < RANDOM_SINGLES) begin
            set_mode(MODE_W'($urandom_range(0, 3)));
            steady = ($urandom_range(0, 4) == 0);
            repeat ($urandom_range(3, 6)) begin
                r = $urandom_range(0, 19);
                if (r < 14)
                    len = $urandom_range(1, MAX_SINGLES);
                else if (r < 17)
                    len = $urandom_range(MAX_SINGLES, MAX_SINGLES + 1);
                else
                    len = $urandom_range(MAX_SINGLES + 2, MAX_SINGLES + 4);
                for (k = 0; k < len; k++)
                    push_random_single(k == len - 1);
                sent += len;
            end
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_singles.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
